[rtl/bsort_pkg.sv]
// Shared types and constants for the bandwidth sort and tier label block.
`timescale 1ns / 1ps
package bsort_pkg;

  localparam int MAX_NODES = 16;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);

  localparam int ID_W   = 10;
  localparam int BW_W   = 24;
  localparam int GAP_W  = 7;
  localparam int TIER_W = 2;
  localparam int PCT_W  = 7;
  localparam int PROD_W = BW_W + PCT_W;

  localparam logic [CNT_W-1:0]  FULL_CNT   = CNT_W'(MAX_NODES);
  localparam logic [GAP_W-1:0]  GAP_RESET  = GAP_W'(20);
  localparam logic [PCT_W-1:0]  PERCENT    = PCT_W'(100);
  localparam logic [TIER_W-1:0] TIER_FAST  = TIER_W'(0);
  localparam logic [TIER_W-1:0] TIER_MAX   = TIER_W'(2);

  typedef struct packed {
    logic [ID_W-1:0] node_id;
    logic [BW_W-1:0] bandwidth;
    logic            last_node;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   out_node_id;
    logic [BW_W-1:0]   out_bandwidth;
    logic [TIER_W-1:0] tier;
    logic              end_of_list;
  } out_item_t;

  // One entry of the sorted list memory.
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [BW_W-1:0] bw;
  } entry_t;

  // Write side of the list memory.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

endpackage

[rtl/bandwidth_sort_and_tier_label_core.sv]
// Bandwidth sort and tier label core: collects node reports into a sorted
// list held in a small memory and, on the report marked last, emits the
// whole list in descending bandwidth order with a tier label on each node.
// Input channel: in_valid/in_ready with one in_item per report. Result
// channel: out_valid/out_ready with one out_item per held node; end_of_list
// marks the final node of a run. Configuration: cfg_valid/cfg_ready writes
// the gap percent, always ready, and is meant to be written while idle.
// An insertion walks down from the tail of the list, with a memory read,
// then a compare and write, for each entry it moves; no new report is
// taken until it ends. No more than 15 entries are held when an insertion
// starts. A last item then emits each node in the steps read, product
// stage, compare and output. A report arriving at a full list is dropped,
// and if it is marked last the emission of the list still starts.
// Reset empties the list and sets the gap percent to 20; memory contents
// are not cleared since only entries below the held count are ever read.
// If the receiver stalls, the output register holds its item and the
// emission walk waits; once the last node sits in the output register the
// block returns to idle and accepts the next report.
`timescale 1ns / 1ps
module bandwidth_sort_and_tier_label_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bsort_pkg::in_item_t         in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bsort_pkg::out_item_t        out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bsort_pkg::GAP_W-1:0] cfg_data
);
  import bsort_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_INS_RD = 7'b0000010,
    S_INS_WR = 7'b0000100,
    S_EM_RD  = 7'b0001000,
    S_EM_DAT = 7'b0010000,
    S_EM_CMP = 7'b0100000,
    S_EM_OUT = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  emit_idx_r, emit_idx_nxt;
  entry_t            new_r, new_nxt;
  logic              last_r, last_nxt;
  entry_t            cur_r, cur_nxt;
  logic [BW_W-1:0]   prev_bw_r, prev_bw_nxt;
  logic [TIER_W-1:0] tier_r, tier_nxt;
  logic [GAP_W-1:0]  gap_r;
  out_item_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  mem_wr_t           mem_wr;
  logic [IDX_W-1:0]  mem_raddr;
  entry_t            mem_rdata;
  logic              step_up;
  logic [CNT_W-1:0]  pos_dec;
  logic [CNT_W-1:0]  emit_inc;

  bsort_mem u_mem (
    .clk   (clk),
    .wr    (mem_wr),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Products are taken while the fresh entry leaves the memory; the compare
  // result is used in the cycle after.
  bsort_tier u_tier (
    .clk     (clk),
    .prev_bw (prev_bw_r),
    .cur_bw  (mem_rdata.bw),
    .gap     (gap_r),
    .step_up (step_up)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign pos_dec  = pos_r - CNT_W'(1);
  assign emit_inc = emit_idx_r + CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    emit_idx_nxt  = emit_idx_r;
    new_nxt       = new_r;
    last_nxt      = last_r;
    cur_nxt       = cur_r;
    prev_bw_nxt   = prev_bw_r;
    tier_nxt      = tier_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    mem_wr.we     = 1'b0;
    mem_wr.addr   = pos_r[IDX_W-1:0];
    mem_wr.data   = new_r;
    mem_raddr     = pos_dec[IDX_W-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          new_nxt.id   = in_item.node_id;
          new_nxt.bw   = in_item.bandwidth;
          last_nxt     = in_item.last_node;
          pos_nxt      = cnt_r;
          emit_idx_nxt = '0;
          tier_nxt     = TIER_FAST;
          if (cnt_r != FULL_CNT) begin
            state_nxt = S_INS_RD;
          end else if (in_item.last_node) begin
            state_nxt = S_EM_RD;
          end
        end
      end
      S_INS_RD: begin
        // Slot zero is reached only when every held entry moved down.
        if (pos_r == '0) begin
          mem_wr.we = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = last_r ? S_EM_RD : S_IDLE;
        end else begin
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        mem_wr.we = 1'b1;
        // Equal bandwidths stay ahead of the new report.
        if (mem_rdata.bw >= new_r.bw) begin
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = last_r ? S_EM_RD : S_IDLE;
        end else begin
          mem_wr.data = mem_rdata;
          pos_nxt     = pos_dec;
          state_nxt   = S_INS_RD;
        end
      end
      S_EM_RD: begin
        mem_raddr = emit_idx_r[IDX_W-1:0];
        state_nxt = S_EM_DAT;
      end
      S_EM_DAT: begin
        cur_nxt   = mem_rdata;
        state_nxt = S_EM_CMP;
      end
      S_EM_CMP: begin
        if ((emit_idx_r != '0) && step_up && (tier_r != TIER_MAX)) begin
          tier_nxt = tier_r + TIER_W'(1);
        end
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.out_node_id   = cur_r.id;
          out_nxt.out_bandwidth = cur_r.bw;
          out_nxt.tier          = tier_r;
          out_nxt.end_of_list   = (emit_inc == cnt_r);
          out_valid_nxt         = 1'b1;
          prev_bw_nxt           = cur_r.bw;
          if (emit_inc == cnt_r) begin
            cnt_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            emit_idx_nxt = emit_inc;
            state_nxt    = S_EM_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      gap_r       <= GAP_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        gap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    emit_idx_r <= emit_idx_nxt;
    new_r      <= new_nxt;
    last_r     <= last_nxt;
    cur_r      <= cur_nxt;
    prev_bw_r  <= prev_bw_nxt;
    tier_r     <= tier_nxt;
    out_r      <= out_nxt;
  end

endmodule

[rtl/bsort_mem.sv]
// Sorted list memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module bsort_mem (
  input  logic                        clk,
  input  bsort_pkg::mem_wr_t          wr,
  input  logic [bsort_pkg::IDX_W-1:0] raddr,
  output bsort_pkg::entry_t           rdata
);
  import bsort_pkg::*;

  entry_t mem [MAX_NODES];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/bsort_tier.sv]
// Tier step test: registered products of the drop and of the gap threshold.
`timescale 1ns / 1ps
module bsort_tier (
  input  logic                        clk,
  input  logic [bsort_pkg::BW_W-1:0]  prev_bw,
  input  logic [bsort_pkg::BW_W-1:0]  cur_bw,
  input  logic [bsort_pkg::GAP_W-1:0] gap,
  output logic                        step_up
);
  import bsort_pkg::*;

  logic [BW_W-1:0]   drop;
  logic [PROD_W-1:0] drop_prod_r;
  logic [PROD_W-1:0] thr_prod_r;

  // The list is sorted descending, so the previous bandwidth never falls
  // below the current one and the drop cannot wrap.
  assign drop = prev_bw - cur_bw;

  always_ff @(posedge clk) begin
    drop_prod_r <= PROD_W'(drop) * PROD_W'(PERCENT);
    thr_prod_r  <= PROD_W'(gap) * PROD_W'(prev_bw);
  end

  assign step_up = drop_prod_r > thr_prod_r;

endmodule
